### rtl/gwp_pkg.sv
// ----------------------------------------------------------------------------
// gwp_pkg
// Shared widths and limits of the greedy weight partitioner.
// ----------------------------------------------------------------------------
`default_nettype none

package gwp_pkg;

  localparam int MAX_PARTS = 32;
  localparam int MAX_SETS  = 32;
  localparam int IDX_W     = $clog2(MAX_PARTS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int WEIGHT_W  = 24;
  localparam int TOTAL_W   = 29;
  localparam int NSET_W    = 6;
  localparam int RANK_W    = 5;

endpackage

`default_nettype wire

### rtl/gwp_in_if.sv
// ----------------------------------------------------------------------------
// gwp_in_if
// Input item channel: one partition weight and the end-of-load flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface gwp_in_if;
  import gwp_pkg::*;

  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic                last;

  modport source (output valid, output weight, output last, input ready);
  modport sink   (input valid, input weight, input last, output ready);

endinterface

`default_nettype wire

### rtl/gwp_out_if.sv
// ----------------------------------------------------------------------------
// gwp_out_if
// Result item channel: one set member record.
// ----------------------------------------------------------------------------
`default_nettype none

interface gwp_out_if;
  import gwp_pkg::*;

  logic               valid;
  logic               ready;
  logic [RANK_W-1:0]  set_rank;
  logic [IDX_W-1:0]   part_index;
  logic [TOTAL_W-1:0] set_total;
  logic               empty_set;
  logic               last_in_set;
  logic               last_of_all;
  logic               too_many;

  modport source (output valid, output set_rank, output part_index, output set_total,
                  output empty_set, output last_in_set, output last_of_all,
                  output too_many, input ready);
  modport sink   (input valid, input set_rank, input part_index, input set_total,
                  input empty_set, input last_in_set, input last_of_all,
                  input too_many, output ready);

endinterface

`default_nettype wire

### rtl/greedy_weight_partitioner.sv
// ----------------------------------------------------------------------------
// greedy_weight_partitioner
// Loads partition weights, assigns them to sets heaviest-first to the lightest
// set, then emits the sets by descending total, one member record per item.
//
//   channel   dir   handshake        contents
//   in_ch     in    valid/ready      weight, last
//   out_ch    out   valid/ready      set_rank, part_index, set_total, flags
//   cfg_*     in    write enable     num_sets
//
// Loading takes one item per cycle; last starts the solve: the set totals are
// cleared, then per partition a weight scan and a set scan (each reads one entry,
// taking partitions in index order, in the one-to-one or single-set case) plus
// one update, then per set a max scan, a member scan and a close. Output stalls
// freeze the member scan and the close. Input is accepted only while loading;
// reset returns to loading.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_weight_partitioner (
  input  wire                  clk,
  input  wire                  rst_n,
  gwp_in_if.sink               in_ch,
  gwp_out_if.source            out_ch,
  input  wire                  cfg_we,
  input  wire [gwp_pkg::NSET_W-1:0] cfg_wdata
);
  import gwp_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_CLR, S_PICK, S_MIN, S_UPD, S_ERK, S_EMB, S_EFIN
  } state_t;

  state_t state_r;

  logic [WEIGHT_W-1:0]      wmem [MAX_PARTS];
  logic [TOTAL_W-1:0]       tmem [MAX_SETS];
  logic [2*IDX_W-1:0]       omem [MAX_PARTS];
  logic [WEIGHT_W-1:0]      wdata;
  logic [TOTAL_W-1:0]       tdata;
  logic [2*IDX_W-1:0]       odata;

  logic [NSET_W-1:0]        cfg_r, ns_r;
  logic [CNT_W-1:0]         cnt_r, n_r, k_r, k_inc;
  logic                     ovf_r;
  logic [IDX_W-1:0]         a_r, hi_r, ri_r;
  logic                     idone_r, rv_r, have_r;
  logic [MAX_PARTS-1:0]     picked_r;
  logic [MAX_SETS-1:0]      used_r;
  logic [IDX_W-1:0]         best_p_r, best_s_r, pend_p_r;
  logic [WEIGHT_W-1:0]      best_w_r;
  logic [TOTAL_W-1:0]       best_t_r;
  logic                     pend_r;
  logic [NSET_W-1:0]        rank_r;

  logic                     out_valid_r;
  logic [RANK_W-1:0]        o_rank_r;
  logic [IDX_W-1:0]         o_part_r;
  logic [TOTAL_W-1:0]       o_total_r;
  logic                     o_empty_r, o_lis_r, o_loa_r, o_tm_r;

  logic                     in_acc, out_free, adv, scan, iss, last_data, ident, out_load;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [NSET_W-1:0]        ns_eff;
  logic [IDX_W-1:0]         ns_m1, n_m1, min_tgt;

  always_comb begin
    in_acc    = in_ch.valid && (state_r == S_LOAD);
    out_free  = !out_valid_r || out_ch.ready;
    adv       = (state_r != S_EMB) || out_free;
    scan      = (state_r == S_PICK) || (state_r == S_MIN) ||
                (state_r == S_ERK) || (state_r == S_EMB);
    iss       = scan && !idone_r && adv;
    last_data = rv_r && (ri_r == hi_r);
    out_load  = ((state_r == S_EMB) && adv && rv_r && pend_r &&
                 (odata[IDX_W-1:0] == best_s_r)) ||
                ((state_r == S_EFIN) && out_free);
    cnt_nxt   = (cnt_r < CNT_W'(MAX_PARTS)) ? cnt_r + 1'b1 : cnt_r;
    if (cfg_r == '0) begin
      ns_eff = NSET_W'(1);
    end else if (cfg_r > NSET_W'(MAX_SETS)) begin
      ns_eff = NSET_W'(MAX_SETS);
    end else begin
      ns_eff = cfg_r;
    end
    ident   = (n_r == CNT_W'(ns_r)) || (ns_r == NSET_W'(1));
    ns_m1   = IDX_W'(ns_r - 1'b1);
    n_m1    = IDX_W'(n_r - 1'b1);
    k_inc   = k_r + 1'b1;
    min_tgt = (ns_r == NSET_W'(1)) ? '0 : k_r[IDX_W-1:0];
  end

  assign in_ch.ready        = (state_r == S_LOAD);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.set_rank    = o_rank_r;
  assign out_ch.part_index  = o_part_r;
  assign out_ch.set_total   = o_total_r;
  assign out_ch.empty_set   = o_empty_r;
  assign out_ch.last_in_set = o_lis_r;
  assign out_ch.last_of_all = o_loa_r;
  assign out_ch.too_many    = o_tm_r;

  // weight store
  always_ff @(posedge clk) begin
    if (in_acc && (cnt_r < CNT_W'(MAX_PARTS))) begin
      wmem[cnt_r[IDX_W-1:0]] <= in_ch.weight;
    end
    if (iss && (state_r == S_PICK)) begin
      wdata <= wmem[a_r];
    end
  end

  // set totals
  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      tmem[a_r] <= '0;
    end else if (state_r == S_UPD) begin
      tmem[best_s_r] <= best_t_r + TOTAL_W'(best_w_r);
    end
    if (iss && ((state_r == S_MIN) || (state_r == S_ERK))) begin
      tdata <= tmem[a_r];
    end
  end

  // assignment order: {partition, set}
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      omem[k_r[IDX_W-1:0]] <= {best_p_r, best_s_r};
    end
    if (iss && (state_r == S_EMB)) begin
      odata <= omem[a_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cfg_r       <= NSET_W'(1);
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      idone_r     <= 1'b0;
      rv_r        <= 1'b0;
      have_r      <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (scan) begin
        if (iss) begin
          a_r <= a_r + 1'b1;
          if (a_r == hi_r) begin
            idone_r <= 1'b1;
          end
        end
        if (adv) begin
          rv_r <= iss;
          ri_r <= a_r;
        end
      end
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            cnt_r <= cnt_nxt;
            if (cnt_r == CNT_W'(MAX_PARTS)) begin
              ovf_r <= 1'b1;
            end
            if (in_ch.last) begin
              ns_r    <= ns_eff;
              n_r     <= cnt_nxt;
              a_r     <= '0;
              state_r <= S_CLR;
            end
          end
        end
        S_CLR: begin
          a_r <= a_r + 1'b1;
          if (a_r == ns_m1) begin
            k_r      <= '0;
            picked_r <= '0;
            a_r      <= '0;
            hi_r     <= ident ? '0 : n_m1;
            idone_r  <= 1'b0;
            rv_r     <= 1'b0;
            have_r   <= 1'b0;
            state_r  <= S_PICK;
          end
        end
        S_PICK: begin
          if (rv_r && !picked_r[ri_r] && (!have_r || (wdata > best_w_r))) begin
            have_r   <= 1'b1;
            best_p_r <= ri_r;
            best_w_r <= wdata;
          end
          if (last_data) begin
            a_r     <= ident ? min_tgt : '0;
            hi_r    <= ident ? min_tgt : ns_m1;
            idone_r <= 1'b0;
            have_r  <= 1'b0;
            state_r <= S_MIN;
          end
        end
        S_MIN: begin
          if (rv_r && (!have_r || (tdata < best_t_r))) begin
            have_r   <= 1'b1;
            best_s_r <= ri_r;
            best_t_r <= tdata;
          end
          if (last_data) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          k_r                <= k_inc;
          picked_r[best_p_r] <= 1'b1;
          idone_r            <= 1'b0;
          rv_r               <= 1'b0;
          have_r             <= 1'b0;
          if (k_inc == n_r) begin
            rank_r  <= '0;
            used_r  <= '0;
            a_r     <= '0;
            hi_r    <= ns_m1;
            state_r <= S_ERK;
          end else begin
            a_r     <= ident ? k_inc[IDX_W-1:0] : '0;
            hi_r    <= ident ? k_inc[IDX_W-1:0] : n_m1;
            state_r <= S_PICK;
          end
        end
        S_ERK: begin
          if (rv_r && !used_r[ri_r] && (!have_r || (tdata > best_t_r))) begin
            have_r   <= 1'b1;
            best_s_r <= ri_r;
            best_t_r <= tdata;
          end
          if (last_data) begin
            a_r     <= '0;
            hi_r    <= n_m1;
            idone_r <= 1'b0;
            pend_r  <= 1'b0;
            state_r <= S_EMB;
          end
        end
        S_EMB: begin
          if (adv && rv_r) begin
            if (odata[IDX_W-1:0] == best_s_r) begin
              if (pend_r) begin
                o_rank_r    <= rank_r[RANK_W-1:0];
                o_part_r    <= pend_p_r;
                o_total_r   <= best_t_r;
                o_empty_r   <= 1'b0;
                o_lis_r     <= 1'b0;
                o_loa_r     <= 1'b0;
                o_tm_r      <= ovf_r;
              end
              pend_r   <= 1'b1;
              pend_p_r <= odata[2*IDX_W-1:IDX_W];
            end
            if (last_data) begin
              state_r <= S_EFIN;
            end
          end
        end
        S_EFIN: begin
          if (out_free) begin
            o_rank_r         <= rank_r[RANK_W-1:0];
            o_part_r         <= pend_r ? pend_p_r : '0;
            o_total_r        <= best_t_r;
            o_empty_r        <= !pend_r;
            o_lis_r          <= 1'b1;
            o_loa_r          <= (rank_r == ns_r - 1'b1);
            o_tm_r           <= ovf_r;
            used_r[best_s_r] <= 1'b1;
            rank_r           <= rank_r + 1'b1;
            a_r              <= '0;
            hi_r             <= ns_m1;
            idone_r          <= 1'b0;
            rv_r             <= 1'b0;
            have_r           <= 1'b0;
            if (rank_r == ns_r - 1'b1) begin
              cnt_r   <= '0;
              ovf_r   <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              state_r <= S_ERK;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
